### hdl/kts_pkg.sv
// keyword token scanner package: payload structs, token kinds, scan modes,
// keyword table lookup functions. no dependencies.
`default_nettype none
package kts_pkg;

  localparam int MAX_TEXT = 256;
  localparam int LEN_W = $clog2(MAX_TEXT + 1);
  localparam int NENTRIES = 39;
  localparam int NKEYWORDS = 12;
  localparam int QDEPTH = 2;

  localparam logic [3:0] TK_COMMA  = 4'd0;
  localparam logic [3:0] TK_SEMI   = 4'd1;
  localparam logic [3:0] TK_COLON  = 4'd2;
  localparam logic [3:0] TK_LPAREN = 4'd3;
  localparam logic [3:0] TK_RPAREN = 4'd4;
  localparam logic [3:0] TK_STRING = 4'd5;
  localparam logic [3:0] TK_NUMBER = 4'd6;
  localparam logic [3:0] TK_WORD   = 4'd7;
  localparam logic [3:0] TK_KEYWORD = 4'd8;
  localparam logic [3:0] TK_ATTR   = 4'd9;
  localparam logic [3:0] TK_BAD    = 4'd10;
  localparam logic [3:0] TK_END    = 4'd11;
  localparam logic [3:0] TK_TEXT   = 4'd12;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_STRING = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;
  localparam logic [1:0] MODE_WORD   = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_mark;
  } req_t;

  typedef struct packed {
    logic [3:0]         token_kind;
    logic [7:0]         text_char;
    logic signed [31:0] num_value;
    logic [3:0]         word_code;
    logic [31:0]        line_no;
    logic               was_cut;
    logic               run_last;
  } rsp_t;

  // one queued request with its scanner context resolved by the front part
  typedef struct packed {
    req_t        req;
    logic [1:0]  mode;
    logic [7:0]  quote;
    logic [32:0] accum;
    logic [NENTRIES-1:0] mask;
    logic [LEN_W-1:0] len;
    logic        cut;
    logic [31:0] line;
    logic [31:0] start;
  } work_t;

  // name packed as 16 bytes, last char in [7:0], zero padded on the left
  function automatic logic [127:0] tbl_name(input int e);
    logic [127:0] s;
    s = '0;
    unique case (e)
      0: s = "skill"; 1: s = "talent"; 2: s = "package"; 3: s = "archetype";
      4: s = "minion"; 5: s = "rival"; 6: s = "nemesis"; 7: s = "weapon";
      8: s = "damage"; 9: s = "dmg"; 10: s = "critical"; 11: s = "crit";
      12: s = "brawn"; 13: s = "agility"; 14: s = "intellect"; 15: s = "cunning";
      16: s = "willpower"; 17: s = "presence"; 18: s = "br"; 19: s = "ag";
      20: s = "int"; 21: s = "cun"; 22: s = "will"; 23: s = "pr";
      24: s = "combat"; 25: s = "social"; 26: s = "general"; 27: s = "cbt";
      28: s = "soc"; 29: s = "gen"; 30: s = "wound"; 31: s = "strain";
      32: s = "soak"; 33: s = "ranged defense"; 34: s = "rangeddefense";
      35: s = "ranged-defense"; 36: s = "melee defense";
      37: s = "melee-defense"; 38: s = "meleedefense";
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] tbl_len(input int e);
    logic [127:0] s;
    logic [4:0] n;
    s = tbl_name(e);
    n = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (s[8*i +: 8] != 8'd0) n = n + 5'd1;
    end
    return n;
  endfunction

  // string literals pack right-aligned; char p counts from the left
  function automatic logic [7:0] tbl_char(input int e, input int p);
    logic [127:0] s;
    logic [4:0] n;
    s = tbl_name(e);
    n = tbl_len(e);
    if (p >= int'(n)) return 8'd0;
    return s[8*(int'(n) - 1 - p) +: 8];
  endfunction

  function automatic logic [3:0] tbl_code(input int e);
    logic [3:0] c;
    unique case (e)
      0, 12, 18: c = 4'd0; 1, 13, 19: c = 4'd1; 2, 14, 20: c = 4'd2;
      3, 15, 21: c = 4'd3; 4, 16, 22: c = 4'd4; 5, 17, 23: c = 4'd5;
      6, 24, 27: c = 4'd6; 7, 25, 28: c = 4'd7; 8, 9, 26, 29: c = 4'd8;
      10, 11, 30: c = 4'd9; 31: c = 4'd10; 32: c = 4'd11;
      33, 34, 35: c = 4'd12; default: c = 4'd13;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### hdl/kts_front.sv
// front part: keeps the scanner state, classifies each request and hands
// the request plus its starting context to the queue. uses kts_pkg.
`default_nettype none
module kts_front import kts_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire req_t  req,
  input  wire logic  req_fire,
  output work_t      work
);
  logic [1:0]  mode, mode_next;
  logic [7:0]  quote, quote_next;
  logic [32:0] accum, accum_next;
  logic [NENTRIES-1:0] mask, mask_next;
  logic [LEN_W-1:0] len, len_next;
  logic        cut, cut_next;
  logic [31:0] line, line_next, start, start_next;

  logic [7:0] c, lc;
  logic is_dig, is_let, restart;
  logic [35:0] mul10;

  always_comb begin
    c = req.in_byte;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    is_dig = c >= "0" && c <= "9";
    is_let = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    mul10 = {3'b0, accum} * 36'd10 + {28'd0, c - 8'd48};
    mode_next = mode; quote_next = quote; accum_next = accum;
    mask_next = mask; len_next = len; cut_next = cut;
    line_next = line; start_next = start;
    restart = 1'b0;
    if (req.end_mark) begin
      mode_next = MODE_IDLE;
    end else begin
      unique case (mode)
        MODE_STRING: begin
          if (c == quote) mode_next = MODE_IDLE;
          else if (c == 8'h0a) begin
            mode_next = MODE_IDLE;
            if (line != '1) line_next = line + 32'd1;
          end else if (len < LEN_W'(MAX_TEXT)) len_next = len + 1'b1;
          else cut_next = 1'b1;
        end
        MODE_NUMBER: begin
          if (is_dig) begin
            accum_next = (mul10 > 36'h80000000) ? 33'h080000000 : mul10[32:0];
          end else begin
            mode_next = MODE_IDLE; restart = 1'b1;
          end
        end
        MODE_WORD: begin
          if (is_let || c == "-") begin
            if (len >= LEN_W'(MAX_TEXT)) begin
              cut_next = 1'b1; mask_next = '0;
            end else begin
              for (int e = 0; e < NENTRIES; e++) begin
                if (int'(len) >= int'(tbl_len(e)) || tbl_char(e, int'(len)) != lc)
                  mask_next[e] = 1'b0;
              end
              len_next = len + 1'b1;
            end
          end else begin
            mode_next = MODE_IDLE; restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase
      if (restart) begin
        if (c == "'" || c == "\"") begin
          mode_next = MODE_STRING; quote_next = c; start_next = line;
          len_next = '0; cut_next = 1'b0;
        end else if (c == 8'h0a) begin
          if (line != '1) line_next = line + 32'd1;
        end else if (c == "-" || c == "+" || is_dig) begin
          mode_next = MODE_NUMBER; quote_next = c; start_next = line;
          accum_next = is_dig ? {25'd0, c - 8'd48} : 33'd0;
        end else if (is_let) begin
          mode_next = MODE_WORD; start_next = line; cut_next = 1'b0;
          len_next = LEN_W'(1);
          for (int e = 0; e < NENTRIES; e++)
            mask_next[e] = tbl_char(e, 0) == lc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE; quote <= '0; accum <= '0; mask <= '1;
      len <= '0; cut <= 1'b0; line <= 32'd1; start <= '0;
    end else if (req_fire) begin
      mode <= mode_next; quote <= quote_next; accum <= accum_next;
      mask <= mask_next; len <= len_next; cut <= cut_next;
      line <= line_next; start <= start_next;
    end
  end

  // context as it stands before this request
  always_comb begin
    work.req = req;
    work.mode = mode;
    work.quote = quote;
    work.accum = accum;
    work.mask = mask;
    work.len = len;
    work.cut = cut;
    work.line = line;
    work.start = start;
  end
endmodule
`default_nettype wire

### hdl/kts_back.sv
// back part: turns one queued request and its context into up to two
// responses, one per cycle while the consumer takes them. uses kts_pkg.
`default_nettype none
module kts_back import kts_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire work_t work,
  input  wire logic  work_valid,
  output logic       work_pop,
  output rsp_t       rsp,
  output logic       rsp_valid,
  input  wire logic  rsp_ready
);
  rsp_t r0, r1;
  logic n0, n1;
  logic second;
  logic [7:0] c;
  logic is_dig, is_let, restart;

  function automatic rsp_t mk(input logic [3:0] k, input logic [7:0] ch,
                              input logic [31:0] v, input logic [3:0] wc,
                              input logic [31:0] ln, input logic ct);
    rsp_t t;
    t.token_kind = k; t.text_char = ch; t.num_value = v; t.word_code = wc;
    t.line_no = ln; t.was_cut = ct; t.run_last = 1'b0;
    return t;
  endfunction

  always_comb begin
    logic [31:0] nv;
    logic hit;
    c = work.req.in_byte;
    is_dig = c >= "0" && c <= "9";
    is_let = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    r0 = '0; r1 = '0; n0 = 1'b0; n1 = 1'b0; restart = 1'b0;
    hit = 1'b0;
    nv = (work.quote == "-") ? 32'd0 - work.accum[31:0] :
         (work.accum > 33'h07fffffff ? 32'h7fffffff : work.accum[31:0]);
    // word close: pick first candidate whose length matches
    if (!work.cut) begin
      for (int e = NENTRIES - 1; e >= 0; e--) begin
        if (work.mask[e] && LEN_W'(tbl_len(e)) == work.len) begin
          hit = 1'b1;
          r0 = mk(e < NKEYWORDS ? TK_KEYWORD : TK_ATTR, 8'd0, 32'd0,
                  tbl_code(e), work.start, 1'b0);
        end
      end
    end
    if (!hit) r0 = mk(TK_WORD, 8'd0, 32'd0, 4'd0, work.start, work.cut);
    if (work.req.end_mark) begin
      unique case (work.mode)
        MODE_STRING: r0 = mk(TK_STRING, 8'd0, 32'd0, 4'd0, work.start, work.cut);
        MODE_NUMBER: r0 = mk(TK_NUMBER, 8'd0, nv, 4'd0, work.start, 1'b0);
        MODE_WORD: ;
        default: r0 = mk(TK_END, 8'd0, 32'd0, 4'd0, work.line, 1'b0);
      endcase
      n0 = 1'b1;
      if (work.mode != MODE_IDLE) begin
        n1 = 1'b1; r1 = mk(TK_END, 8'd0, 32'd0, 4'd0, work.line, 1'b0);
      end
    end else begin
      unique case (work.mode)
        MODE_STRING: begin
          if (c == work.quote || c == 8'h0a) begin
            n0 = 1'b1; r0 = mk(TK_STRING, 8'd0, 32'd0, 4'd0, work.start, work.cut);
          end else if (work.len < LEN_W'(MAX_TEXT)) begin
            n0 = 1'b1; r0 = mk(TK_TEXT, c, 32'd0, 4'd0, work.start, 1'b0);
          end
        end
        MODE_NUMBER: begin
          if (!is_dig) begin
            n0 = 1'b1; r0 = mk(TK_NUMBER, 8'd0, nv, 4'd0, work.start, 1'b0);
            restart = 1'b1;
          end
        end
        MODE_WORD: begin
          if (is_let || c == "-") begin
            if (work.len < LEN_W'(MAX_TEXT)) begin
              n0 = 1'b1; r0 = mk(TK_TEXT, c, 32'd0, 4'd0, work.start, 1'b0);
            end
          end else begin
            n0 = 1'b1; restart = 1'b1;
          end
        end
        default: restart = 1'b1;
      endcase
      if (restart) begin
        rsp_t s;
        logic ns;
        ns = 1'b1;
        unique case (c)
          ",": s = mk(TK_COMMA, 8'd0, 32'd0, 4'd0, work.line, 1'b0);
          ";": s = mk(TK_SEMI, 8'd0, 32'd0, 4'd0, work.line, 1'b0);
          ":": s = mk(TK_COLON, 8'd0, 32'd0, 4'd0, work.line, 1'b0);
          "(": s = mk(TK_LPAREN, 8'd0, 32'd0, 4'd0, work.line, 1'b0);
          ")": s = mk(TK_RPAREN, 8'd0, 32'd0, 4'd0, work.line, 1'b0);
          default: begin
            if (is_let) s = mk(TK_TEXT, c, 32'd0, 4'd0, work.line, 1'b0);
            else s = mk(TK_BAD, 8'd0, 32'd0, 4'd0, work.line, 1'b0);
            ns = !(c == "'" || c == "\"" || c == " " || c == 8'h09 ||
                   c == 8'h0d || c == 8'h0a || c == "-" || c == "+" || is_dig);
          end
        endcase
        if (n0) begin
          n1 = ns; r1 = s;
        end else begin
          n0 = ns; r0 = s;
        end
      end
    end
    r0.run_last = !n1;
    r1.run_last = 1'b1;
  end

  // output register acts as the skid stage toward the consumer
  logic out_free;
  assign out_free = !rsp_valid || rsp_ready;
  assign work_pop = work_valid && out_free && (second || !n0 || !n1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0; second <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= 1'b0;
      if (work_valid) begin
        if (second) begin
          rsp <= r1; rsp_valid <= 1'b1; second <= 1'b0;
        end else if (n0) begin
          rsp <= r0; rsp_valid <= 1'b1; second <= n1;
        end else if (n1) begin
          rsp <= r1; rsp_valid <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### hdl/kts_queue.sv
// short fifo between front and back parts. uses kts_pkg.
`default_nettype none
module kts_queue import kts_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire work_t wr_data,
  input  wire logic  wr_en,
  output logic       full,
  output work_t      rd_data,
  output logic       rd_valid,
  input  wire logic  rd_en
);
  localparam int AW = $clog2(QDEPTH);
  work_t mem [QDEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;

  assign full = cnt == (AW+1)'(QDEPTH);
  assign rd_valid = cnt != '0;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr_en) wp <= wp + 1'b1;
      if (rd_en) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end
endmodule
`default_nettype wire

### hdl/keyword_token_scanner.sv
// keyword token scanner top level: front part, queue, back part.
// uses kts_pkg, kts_front, kts_queue, kts_back.
`default_nettype none
// one request (a source byte or an end mark) is taken per cycle while the
// two-entry queue has room; each request yields zero, one or two responses,
// and the back part issues one response per cycle while the consumer is
// ready, so a request that yields two responses holds the back part until
// both are issued. the front part updates the scanner state (mode, line
// counter, number accumulator, keyword candidate mask) when the request is
// taken; the back part formats tokens from the context queued with it.
module keyword_token_scanner import kts_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire req_t in_data,
  input  wire logic in_valid,
  output logic      in_ready,
  output rsp_t      out_data,
  output logic      out_valid,
  input  wire logic out_ready
);
  work_t fw, bw;
  logic q_full, q_valid, q_pop, fire;

  assign in_ready = !q_full;
  assign fire = in_valid && in_ready;

  // front: state update per accepted request
  kts_front u_front (.clk, .rst, .req(in_data), .req_fire(fire), .work(fw));

  // queue: decouples request intake from response output
  kts_queue u_queue (.clk, .rst, .wr_data(fw), .wr_en(fire), .full(q_full),
                     .rd_data(bw), .rd_valid(q_valid), .rd_en(q_pop));

  // back: token formatting and response sequencing
  kts_back u_back (.clk, .rst, .work(bw), .work_valid(q_valid), .work_pop(q_pop),
                   .rsp(out_data), .rsp_valid(out_valid), .rsp_ready(out_ready));
endmodule
`default_nettype wire

### hdl/kts_checker.sv
// port-level checker for the keyword token scanner, bound to the top level.
// uses kts_pkg.
`default_nettype none
module kts_checker import kts_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire req_t in_data,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire rsp_t out_data,
  input wire logic out_valid,
  input wire logic out_ready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("response dropped while stalled");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.token_kind <= TK_TEXT)
    else $error("bad token kind");
  a_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.token_kind != TK_TEXT |-> out_data.text_char == 8'd0)
    else $error("text char on non-text token");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("response after reset");
endmodule
bind keyword_token_scanner kts_checker u_kts_checker (.*);
`default_nettype wire

### tb/sv/keyword_token_scanner_test.sv
// testbench for keyword_token_scanner: byte and end-mark requests against a
// built-in scanner model, responses checked field by field. uses kts_pkg.
`timescale 1ns / 1ps
module keyword_token_scanner_test;
  import kts_pkg::*;

  logic clk;
  logic rst;
  req_t in_data;
  logic in_valid;
  logic in_ready;
  rsp_t out_data;
  logic out_valid;
  logic out_ready;

  keyword_token_scanner i_dut (
    .clk(clk), .rst(rst), .in_data(in_data), .in_valid(in_valid),
    .in_ready(in_ready), .out_data(out_data), .out_valid(out_valid),
    .out_ready(out_ready)
  );

  // keyword table as the scanner sees it
  localparam int NWORDS = 39;
  localparam int NKW = 12;
  string word_names [NWORDS] = '{
    "skill", "talent", "package", "archetype", "minion", "rival", "nemesis",
    "weapon", "damage", "dmg", "critical", "crit", "brawn", "agility",
    "intellect", "cunning", "willpower", "presence", "br", "ag", "int", "cun",
    "will", "pr", "combat", "social", "general", "cbt", "soc", "gen", "wound",
    "strain", "soak", "ranged defense", "rangeddefense", "ranged-defense",
    "melee defense", "melee-defense", "meleedefense"};
  logic [3:0] word_codes [NWORDS] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 8, 8, 9, 9, 0, 1, 2, 3, 4, 5, 0, 1, 2, 3, 4, 5,
    6, 7, 8, 6, 7, 8, 9, 10, 11, 12, 12, 12, 13, 13, 13};

  // model state
  logic [1:0] scan_st;
  logic [31:0] cur_line;
  logic [31:0] tok_line;
  int text_len;
  logic [7:0] open_ch;
  logic [32:0] magnitude;
  logic [NWORDS-1:0] candidates;
  logic cut_seen;

  req_t pending_reqs [$];
  rsp_t expected_tokens [$];
  rsp_t step_out [$];

  int mismatches;
  int tokens_checked;
  int long_hold;
  bit hold_request;
  bit sender_pause;
  int cycles;
  bit stim_done;

  // ---------------------------------------------------------------------
  // scanner model
  // ---------------------------------------------------------------------
  function automatic rsp_t mk_tok(logic [3:0] kind, logic [7:0] ch,
                                  logic [31:0] val, logic [3:0] code,
                                  logic [31:0] ln, logic cut);
    rsp_t r;
    r.token_kind = kind;
    r.text_char = ch;
    r.num_value = val;
    r.word_code = code;
    r.line_no = ln;
    r.was_cut = cut;
    r.run_last = 1'b0;
    return r;
  endfunction

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic bump_line();
    if (cur_line != 32'hFFFF_FFFF) cur_line = cur_line + 1;
  endtask

  task automatic add_word_char(logic [7:0] c);
    logic [7:0] lc;
    string nm;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    if (text_len >= MAX_TEXT) begin
      cut_seen = 1'b1;
      candidates = '0;
      return;
    end
    for (int e = 0; e < NWORDS; e++) begin
      nm = word_names[e];
      if (candidates[e] && (text_len >= nm.len() || nm[text_len] != lc))
        candidates[e] = 1'b0;
    end
    text_len++;
    step_out.push_back(mk_tok(TK_TEXT, c, 0, 0, tok_line, 0));
  endtask

  task automatic finish_word();
    scan_st = MODE_IDLE;
    if (!cut_seen) begin
      for (int e = 0; e < NWORDS; e++) begin
        if (candidates[e] && word_names[e].len() == text_len) begin
          step_out.push_back(mk_tok(e < NKW ? TK_KEYWORD : TK_ATTR, 0, 0,
                                    word_codes[e], tok_line, 0));
          return;
        end
      end
    end
    step_out.push_back(mk_tok(TK_WORD, 0, 0, 0, tok_line, cut_seen));
  endtask

  task automatic finish_number();
    logic [31:0] v;
    scan_st = MODE_IDLE;
    if (open_ch == "-") v = 32'd0 - magnitude[31:0];
    else v = (magnitude > 33'h7FFF_FFFF) ? 32'h7FFF_FFFF : magnitude[31:0];
    step_out.push_back(mk_tok(TK_NUMBER, 0, v, 0, tok_line, 0));
  endtask

  task automatic finish_string();
    scan_st = MODE_IDLE;
    step_out.push_back(mk_tok(TK_STRING, 0, 0, 0, tok_line, cut_seen));
  endtask

  task automatic scan_fresh(logic [7:0] c);
    case (c)
      ",": step_out.push_back(mk_tok(TK_COMMA, 0, 0, 0, cur_line, 0));
      ";": step_out.push_back(mk_tok(TK_SEMI, 0, 0, 0, cur_line, 0));
      ":": step_out.push_back(mk_tok(TK_COLON, 0, 0, 0, cur_line, 0));
      "(": step_out.push_back(mk_tok(TK_LPAREN, 0, 0, 0, cur_line, 0));
      ")": step_out.push_back(mk_tok(TK_RPAREN, 0, 0, 0, cur_line, 0));
      "'", "\"": begin
        scan_st = MODE_STRING;
        open_ch = c;
        tok_line = cur_line;
        text_len = 0;
        cut_seen = 1'b0;
      end
      " ", 8'h09, 8'h0D: ;
      8'h0A: bump_line();
      default: begin
        if (c == "-" || c == "+" || digit(c)) begin
          scan_st = MODE_NUMBER;
          open_ch = c;
          magnitude = digit(c) ? 33'(c - "0") : 33'd0;
          tok_line = cur_line;
        end else if (letter(c)) begin
          scan_st = MODE_WORD;
          tok_line = cur_line;
          text_len = 0;
          cut_seen = 1'b0;
          candidates = '1;
          add_word_char(c);
        end else begin
          step_out.push_back(mk_tok(TK_BAD, 0, 0, 0, cur_line, 0));
        end
      end
    endcase
  endtask

  // advance the model by one request and queue the tokens it yields
  task automatic predict_tokens(req_t r);
    logic [7:0] c;
    logic [35:0] wide;
    rsp_t t;
    c = r.in_byte;
    step_out.delete();
    if (r.end_mark) begin
      if (scan_st == MODE_STRING) finish_string();
      else if (scan_st == MODE_NUMBER) finish_number();
      else if (scan_st == MODE_WORD) finish_word();
      scan_st = MODE_IDLE;
      step_out.push_back(mk_tok(TK_END, 0, 0, 0, cur_line, 0));
    end else if (scan_st == MODE_STRING) begin
      if (c == open_ch) finish_string();
      else if (c == 8'h0A) begin
        bump_line();
        finish_string();
      end else if (text_len < MAX_TEXT) begin
        text_len++;
        step_out.push_back(mk_tok(TK_TEXT, c, 0, 0, tok_line, 0));
      end else cut_seen = 1'b1;
    end else if (scan_st == MODE_NUMBER) begin
      if (digit(c)) begin
        // wide enough for the saturated magnitude times ten
        wide = 36'(magnitude) * 36'd10 + 36'(c - "0");
        magnitude = (wide > 36'h8000_0000) ? 33'h8000_0000 : wide[32:0];
      end else begin
        finish_number();
        scan_fresh(c);
      end
    end else if (scan_st == MODE_WORD) begin
      if (letter(c) || c == "-") add_word_char(c);
      else begin
        finish_word();
        scan_fresh(c);
      end
    end else begin
      scan_fresh(c);
    end
    for (int i = 0; i < step_out.size(); i++) begin
      t = step_out[i];
      if (i == step_out.size() - 1) t.run_last = 1'b1;
      expected_tokens.push_back(t);
    end
  endtask

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_byte(logic [7:0] c);
    req_t r;
    r.in_byte = c;
    r.end_mark = 1'b0;
    pending_reqs.push_back(r);
  endtask

  task automatic push_end();
    req_t r;
    r.in_byte = 8'($urandom);   // ignored by the scanner, still toggled
    r.end_mark = 1'b1;
    pending_reqs.push_back(r);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'("a" + $urandom_range(0, 25));
    if ($urandom_range(0, 2) == 0) c = c - 8'd32;
    return c;
  endfunction

  function automatic logic [7:0] rand_sep();
    case ($urandom_range(0, 9))
      0: return ",";
      1: return ";";
      2: return ":";
      3: return "(";
      4: return ")";
      5: return 8'h0A;
      6: return 8'h09;
      default: return " ";
    endcase
  endfunction

  // one fragment with random content: mostly well-formed, at times a single random byte
  task automatic push_fragment();
    string s;
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        s = word_names[$urandom_range(0, NWORDS - 1)];
        for (int i = 0; i < s.len(); i++)
          push_byte(($urandom_range(0, 3) == 0 && s[i] >= "a" && s[i] <= "z")
                    ? s[i] - 8'd32 : s[i]);
      end
      3, 4: begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          push_byte($urandom_range(0, 6) == 0 ? "-" : rand_letter());
      end
      5, 6: begin
        if ($urandom_range(0, 2) == 0) push_byte($urandom_range(0, 1) ? "-" : "+");
        n = $urandom_range(0, ($urandom_range(0, 5) == 0) ? 14 : 4);
        for (int i = 0; i < n; i++) push_byte(8'("0" + $urandom_range(0, 9)));
      end
      7, 8: begin
        logic [7:0] q;
        q = $urandom_range(0, 1) ? "'" : "\"";
        push_byte(q);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) push_byte(8'($urandom_range(1, 255)) | 8'h80);
        push_byte($urandom_range(0, 4) == 0 ? 8'h0A : q);
      end
      default: push_byte(8'($urandom));
    endcase
  endtask

  // ---------------------------------------------------------------------
  // clock, driver, monitor
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // sender: bursts of random length, random gaps between them
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (!in_valid || in_ready) begin
        // previous request gone (or none offered): decide on the next one
        if (gap_left > 0 || sender_pause || pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else burst_left <= burst_left - 1;
        end
      end
    end
  end

  // model runs on every accepted request
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) predict_tokens(in_data);
  end

  // receiver: own stall pattern, plus a long hold-off on request
  logic [2:0] stall_phase;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_phase <= '0;
      long_hold <= 0;
    end else begin
      stall_phase <= stall_phase + 3'($urandom_range(1, 2));
      if (hold_request && long_hold == 0) begin
        long_hold <= 300;
        out_ready <= 1'b0;
      end else if (long_hold > 1) begin
        long_hold <= long_hold - 1;
        out_ready <= 1'b0;
      end else begin
        long_hold <= 0;
        out_ready <= (stall_phase < 3'd5) || ($urandom_range(0, 3) == 0);
      end
    end
  end

  // compare each response against the oldest expected token
  rsp_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response kind=%0d line=%0d", out_data.token_kind,
                   out_data.line_no);
      end else begin
        want = expected_tokens.pop_front();
        tokens_checked++;
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind=%0d ch=%0h val=%0d code=%0d line=%0d cut=%0b last=%0b got kind=%0d ch=%0h val=%0d code=%0d line=%0d cut=%0b last=%0b",
                     want.token_kind, want.text_char, want.num_value, want.word_code,
                     want.line_no, want.was_cut, want.run_last,
                     out_data.token_kind, out_data.text_char, out_data.num_value,
                     out_data.word_code, out_data.line_no, out_data.was_cut,
                     out_data.run_last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int n;
    rst = 1'b1;
    mismatches = 0;
    tokens_checked = 0;
    cycles = 0;
    hold_request = 1'b0;
    sender_pause = 1'b0;
    stim_done = 1'b0;
    scan_st = MODE_IDLE;
    cur_line = 1;
    tok_line = 0;
    text_len = 0;
    open_ch = 0;
    magnitude = 0;
    candidates = '1;
    cut_seen = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: punctuation, keywords, attributes, numbers at the limits, strings, stray bytes and end marks
    push_text(",;:()");
    push_text("SKILL Ranged-Defense melee defense ");
    push_text("-2147483648 +99999999999 - 2147483647");
    push_text("'a\"b' \"x\n");
    push_byte(8'h00);
    push_byte(8'h0C);
    push_byte(8'hFF);
    push_text("use");
    push_end();
    push_end();
    while (pending_reqs.size() > 0 || expected_tokens.size() > 0) @(posedge clk);

    // overlong word and string, both dropping bytes past the limit
    for (int i = 0; i < MAX_TEXT + 3; i++) push_byte(rand_letter());
    push_byte(" ");
    push_byte("\"");
    for (int i = 0; i < MAX_TEXT + 3; i++) push_byte(8'($urandom_range(32, 126)) | 8'h01);
    push_end();

    // long receiver hold-off while the sender keeps offering
    for (int i = 0; i < 40; i++) push_fragment();
    hold_request = 1'b1;
    wait (long_hold != 0);
    hold_request = 1'b0;
    while (pending_reqs.size() > 0 || in_valid) @(posedge clk);

    // sender pauses until everything has drained
    sender_pause = 1'b1;
    while (expected_tokens.size() > 0) @(posedge clk);
    sender_pause = 1'b0;

    // random part: mostly well-formed fragments with separators, some noise
    n = 0;
    while (n < 350) begin
      if ($urandom_range(0, 9) == 0) begin
        push_byte(8'($urandom));
        n++;
      end else begin
        n -= pending_reqs.size();
        push_fragment();
        push_byte(rand_sep());
        n += pending_reqs.size();
      end
      if ($urandom_range(0, 60) == 0) begin
        push_end();
        n++;
      end
      while (pending_reqs.size() > 16) @(posedge clk);
    end
    push_end();

    while (pending_reqs.size() > 0 || in_valid) @(posedge clk);
    while (expected_tokens.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("scanned punctuation, strings, numbers, keywords and attributes");
    $display("%0d tokens checked, %0d mismatches", tokens_checked, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
